@@ hdl/three_band_audio_energy_core_macros.svh @@
// assertion macros of the three band energy core, used by the tbae_seq file
// no dependencies; taken in by `include where assertions are written
`ifndef THREE_BAND_AUDIO_ENERGY_CORE_MACROS_SVH
`define THREE_BAND_AUDIO_ENERGY_CORE_MACROS_SVH

// same-cycle implication, off while reset is held
`define TBAE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define TBAE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tbae_pkg.sv @@
// shared constants, codes and types of the three band energy core
// no dependencies
`timescale 1ns / 1ps

package tbae_pkg;

    localparam int NUM_TAPS  = 32;
    localparam int ADDR_W    = $clog2(NUM_TAPS);
    localparam int NUM_BANDS = 3;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int Q_SHIFT   = 15;
    localparam int PROD_W    = 32;
    localparam int TERM_W    = PROD_W - Q_SHIFT;
    localparam int FILT_W    = TERM_W + $clog2(NUM_TAPS);
    localparam int ENERGY_W  = 32;
    localparam int RATIO_W   = 8;
    localparam int INDEX_W   = 8;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd8;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_COEF   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] BAND_BASS   = 2'd0;
    localparam logic [1:0] BAND_MID    = 2'd1;
    localparam logic [1:0] BAND_TREBLE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAPS,
        ST_DRAIN,
        ST_SQUARE,
        ST_FINISH
    } tbae_state_t;

    typedef struct packed {
        logic lane_load;
        logic lane_square;
        logic acc_mac;
        logic acc_square;
        logic filt_clear;
        logic energy_clear;
    } tbae_ctrl_t;

endpackage

@@ hdl/three_band_audio_energy_core.sv @@
// top level of the three band audio energy core: delay line, coefficient stores,
// sequencer and shared multiply unit; depends on tbae_pkg, tbae_ram, tbae_seq, tbae_mac_unit
//
// channel  direction  handshake            payload
// s_       in         s_tvalid / s_tready  s_tuser kind, s_tdata sample or coefficient
// m_       out        m_tvalid / m_tready  m_tdata three band energies
// cfg_     in         cfg_wr_en            cfg_wr_data decimation ratio
//
// filter run: one tap per cycle through the delay line read port and the three shared multiply
// lanes, then one squaring pass; not ready meanwhile
// read waits during a filter run and while a previous result is still held and m_tready is low
// reset: synchronous; store valid bits clear at once, no clearing pass
`timescale 1ns / 1ps

module three_band_audio_energy_core
    import tbae_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [RATIO_W-1:0]        cfg_wr_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [63:0]               s_tdata,   // left, right, coef_band, coef_index, coef_value
    input  logic [1:0]                s_tuser,   // kind
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [3*ENERGY_W-1:0]     m_tdata    // bass_energy, mid_energy, treble_energy
);

    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [1:0]                 coef_band;
    logic [INDEX_W-1:0]         coef_index;
    logic [COEF_W-1:0]          coef_value;

    logic                       sample_we;
    logic [ADDR_W-1:0]          sample_waddr;
    logic [SAMPLE_W-1:0]        sample_wdata;
    logic [ADDR_W-1:0]          sample_raddr;
    logic [SAMPLE_W-1:0]        sample_rdata;
    logic [NUM_BANDS-1:0]       coef_we;
    logic [ADDR_W-1:0]          coef_waddr;
    logic [ADDR_W-1:0]          coef_raddr;
    logic [COEF_W-1:0]          coef_rdata [NUM_BANDS];
    logic signed [COEF_W-1:0]   coef_data  [NUM_BANDS];
    logic [ENERGY_W-1:0]        energy_out [NUM_BANDS];
    tbae_ctrl_t                 ctrl;

    assign left       = s_tdata[15:0];
    assign right      = s_tdata[31:16];
    assign coef_band  = s_tdata[33:32];
    assign coef_index = s_tdata[41:34];
    assign coef_value = s_tdata[57:42];

    tbae_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .kind         (s_tuser),
        .left         (left),
        .right        (right),
        .coef_band    (coef_band),
        .coef_index   (coef_index),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .sample_we    (sample_we),
        .sample_waddr (sample_waddr),
        .sample_wdata (sample_wdata),
        .sample_raddr (sample_raddr),
        .coef_we      (coef_we),
        .coef_waddr   (coef_waddr),
        .coef_raddr   (coef_raddr),
        .ctrl         (ctrl)
    );

    tbae_ram #(
        .DEPTH (NUM_TAPS),
        .WIDTH (SAMPLE_W)
    ) u_sample_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (sample_we),
        .waddr   (sample_waddr),
        .wdata   (sample_wdata),
        .raddr   (sample_raddr),
        .rdata   (sample_rdata)
    );

    for (genvar b = 0; b < NUM_BANDS; b++) begin : g_coef
        tbae_ram #(
            .DEPTH (NUM_TAPS),
            .WIDTH (COEF_W)
        ) u_coef_ram (
            .aclk    (aclk),
            .aresetn (aresetn),
            .we      (coef_we[b]),
            .waddr   (coef_waddr),
            .wdata   (coef_value),
            .raddr   (coef_raddr),
            .rdata   (coef_rdata[b])
        );
        assign coef_data[b] = coef_rdata[b];
    end

    tbae_mac_unit u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .coef_data   (coef_data),
        .sample_data (sample_rdata),
        .energy_out  (energy_out)
    );

    assign m_tdata = {energy_out[2], energy_out[1], energy_out[0]};

endmodule

@@ hdl/tbae_ram.sv @@
// generic single write, single registered read memory with per-entry valid bits
// unwritten entries read as zero; no dependencies
`timescale 1ns / 1ps

module tbae_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

@@ hdl/tbae_mac_unit.sv @@
// shared three-lane multiplier with filter and energy accumulators
// depends on tbae_pkg; driven by tbae_seq
`timescale 1ns / 1ps

module tbae_mac_unit
    import tbae_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tbae_ctrl_t                 ctrl,
    input  logic signed [COEF_W-1:0]   coef_data [NUM_BANDS],
    input  logic signed [SAMPLE_W-1:0] sample_data,
    output logic [ENERGY_W-1:0]        energy_out [NUM_BANDS]
);

    logic signed [FILT_W-1:0]   op_a       [NUM_BANDS];
    logic signed [FILT_W-1:0]   op_b       [NUM_BANDS];
    logic signed [2*FILT_W-1:0] full_prod  [NUM_BANDS];
    logic [PROD_W-1:0]          prod_reg   [NUM_BANDS];
    logic signed [FILT_W-1:0]   term       [NUM_BANDS];
    logic [ENERGY_W-1:0]        sq_term    [NUM_BANDS];
    logic signed [FILT_W-1:0]   filt_reg   [NUM_BANDS];
    logic [ENERGY_W-1:0]        energy_reg [NUM_BANDS];
    logic [ENERGY_W-1:0]        out_reg    [NUM_BANDS];

    always_comb begin
        for (int b = 0; b < NUM_BANDS; b++) begin
            if (ctrl.lane_square) begin
                op_a[b] = filt_reg[b];
                op_b[b] = filt_reg[b];
            end else begin
                op_a[b] = {{(FILT_W-COEF_W){coef_data[b][COEF_W-1]}}, coef_data[b]};
                op_b[b] = {{(FILT_W-SAMPLE_W){sample_data[SAMPLE_W-1]}}, sample_data};
            end
            full_prod[b] = op_a[b] * op_b[b];
            term[b] = {{(FILT_W-TERM_W){prod_reg[b][PROD_W-1]}},
                       prod_reg[b][PROD_W-1:Q_SHIFT]};
            sq_term[b] = {{Q_SHIFT{prod_reg[b][PROD_W-1]}}, prod_reg[b][PROD_W-1:Q_SHIFT]};
        end
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < NUM_BANDS; b++) begin
            if (ctrl.lane_load) begin
                prod_reg[b] <= full_prod[b][PROD_W-1:0];
            end
            if (ctrl.filt_clear) begin
                filt_reg[b] <= '0;
            end else if (ctrl.acc_mac) begin
                filt_reg[b] <= filt_reg[b] + term[b];
            end
            if (ctrl.energy_clear) begin
                out_reg[b] <= energy_reg[b];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                energy_reg[b] <= '0;
            end
        end else begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                if (ctrl.energy_clear) begin
                    energy_reg[b] <= '0;
                end else if (ctrl.acc_square) begin
                    energy_reg[b] <= energy_reg[b] + sq_term[b];
                end
            end
        end
    end

    assign energy_out = out_reg;

endmodule

@@ hdl/tbae_seq.sv @@
// sequencer: handshakes, decimation, delay line pointers and tap stepping
// depends on tbae_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "three_band_audio_energy_core_macros.svh"

module tbae_seq
    import tbae_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [RATIO_W-1:0]         cfg_wr_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 kind,
    input  logic signed [SAMPLE_W-1:0] left,
    input  logic signed [SAMPLE_W-1:0] right,
    input  logic [1:0]                 coef_band,
    input  logic [INDEX_W-1:0]         coef_index,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic                       sample_we,
    output logic [ADDR_W-1:0]          sample_waddr,
    output logic [SAMPLE_W-1:0]        sample_wdata,
    output logic [ADDR_W-1:0]          sample_raddr,
    output logic [NUM_BANDS-1:0]       coef_we,
    output logic [ADDR_W-1:0]          coef_waddr,
    output logic [ADDR_W-1:0]          coef_raddr,
    output tbae_ctrl_t                 ctrl
);

    localparam logic [ADDR_W-1:0] LAST_TAP = ADDR_W'(NUM_TAPS - 1);

    tbae_state_t        state_reg, state_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [RATIO_W-1:0] decim_reg, decim_next;
    logic [ADDR_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [ADDR_W-1:0]  tap_cnt_reg, tap_cnt_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic               rd_v_reg, rd_v_next;
    logic               prod_v_reg, prod_v_next;
    logic               prod_sq_reg, prod_sq_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic               accept;
    logic               sample_xfer;
    logic               read_xfer;
    logic               fire;
    logic [RATIO_W-1:0] decim_inc;
    logic [SAMPLE_W:0]  lr_sum;
    logic               index_ok;

    assign accept      = s_tvalid && s_tready;
    assign sample_xfer = accept && (kind == KIND_SAMPLE);
    assign read_xfer   = accept && (kind == KIND_READ);
    assign decim_inc   = decim_reg + RATIO_W'(1);
    assign fire        = decim_inc >= ratio_reg;
    assign lr_sum      = {left[SAMPLE_W-1], left} + {right[SAMPLE_W-1], right};
    assign index_ok    = {1'b0, coef_index} < (INDEX_W + 1)'(NUM_TAPS);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (sample_xfer && fire) begin
                    state_next = ST_TAPS;
                end
            end
            ST_TAPS: begin
                if (tap_cnt_reg == LAST_TAP) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_v_reg && !prod_v_reg) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE)
                   && !((kind == KIND_READ) && m_tvalid_reg && !m_tready);
        ctrl.lane_load    = rd_v_reg || (state_reg == ST_SQUARE);
        ctrl.lane_square  = (state_reg == ST_SQUARE);
        ctrl.acc_mac      = prod_v_reg && !prod_sq_reg;
        ctrl.acc_square   = prod_v_reg && prod_sq_reg;
        ctrl.filt_clear   = sample_xfer && fire;
        ctrl.energy_clear = read_xfer;
        sample_we    = sample_xfer;
        sample_waddr = wr_pos_reg;
        sample_wdata = lr_sum[SAMPLE_W:1];
        sample_raddr = rd_ptr_reg;
        coef_raddr   = tap_cnt_reg;
        coef_waddr   = coef_index[ADDR_W-1:0];
        coef_we      = '0;
        if (accept && (kind == KIND_COEF) && index_ok) begin
            case (coef_band)
                BAND_BASS:   coef_we[0] = 1'b1;
                BAND_MID:    coef_we[1] = 1'b1;
                BAND_TREBLE: coef_we[2] = 1'b1;
                default:     coef_we = '0;
            endcase
        end
        m_tvalid = m_tvalid_reg;
    end

    // counters, pointers and pipeline tags
    always_comb begin
        ratio_next    = cfg_wr_en ? cfg_wr_data : ratio_reg;
        decim_next    = decim_reg;
        wr_pos_next   = wr_pos_reg;
        tap_cnt_next  = tap_cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_v_next     = (state_reg == ST_TAPS);
        prod_v_next   = rd_v_reg || (state_reg == ST_SQUARE);
        prod_sq_next  = (state_reg == ST_SQUARE);
        m_tvalid_next = m_tvalid_reg;
        if (sample_xfer) begin
            decim_next  = fire ? '0 : decim_inc;
            wr_pos_next = (wr_pos_reg == '0) ? LAST_TAP : wr_pos_reg - ADDR_W'(1);
            if (fire) begin
                tap_cnt_next = '0;
                rd_ptr_next  = wr_pos_reg;
            end
        end
        if (state_reg == ST_TAPS) begin
            tap_cnt_next = tap_cnt_reg + ADDR_W'(1);
            rd_ptr_next  = (rd_ptr_reg == LAST_TAP) ? '0 : rd_ptr_reg + ADDR_W'(1);
        end
        if (read_xfer) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ratio_reg    <= RATIO_RESET;
            decim_reg    <= '0;
            wr_pos_reg   <= LAST_TAP;
            tap_cnt_reg  <= '0;
            rd_ptr_reg   <= '0;
            rd_v_reg     <= 1'b0;
            prod_v_reg   <= 1'b0;
            prod_sq_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ratio_reg    <= ratio_next;
            decim_reg    <= decim_next;
            wr_pos_reg   <= wr_pos_next;
            tap_cnt_reg  <= tap_cnt_next;
            rd_ptr_reg   <= rd_ptr_next;
            rd_v_reg     <= rd_v_next;
            prod_v_reg   <= prod_v_next;
            prod_sq_reg  <= prod_sq_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `TBAE_ASSERT_NOW(a_square_empty, aclk, aresetn, state_reg == ST_SQUARE, !rd_v_reg && !prod_v_reg, "square launched with taps in flight")
    `TBAE_ASSERT_NOW(a_finish_square, aclk, aresetn, state_reg == ST_FINISH, prod_v_reg && prod_sq_reg, "finish without square product")
    `TBAE_ASSERT_NEXT(a_pos_steps, aclk, aresetn, sample_xfer, wr_pos_reg != $past(wr_pos_reg), "write position did not step")

endmodule

@@ test/three_band_audio_energy_checker.sv @@
// checker for the three band audio energy core: watches config, input and result transfers,
// keeps its own copy of delay line, coefficients and energies and compares each result
// depends on tbae_pkg
`timescale 1ns / 1ps

module three_band_audio_energy_checker
    import tbae_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [RATIO_W-1:0]    cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [63:0]           s_tdata,   // left, right, coef_band, coef_index, coef_value
    input  logic [1:0]            s_tuser,   // kind
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [3*ENERGY_W-1:0] m_tdata,   // bass_energy, mid_energy, treble_energy
    output int                    fail_count,
    output int                    outstanding,
    output int                    reads_checked,
    output int                    filter_runs
);

    typedef struct {
        logic [ENERGY_W-1:0] bass;
        logic [ENERGY_W-1:0] mid;
        logic [ENERGY_W-1:0] treble;
    } energies_t;

    logic signed [SAMPLE_W-1:0] sample_line [NUM_TAPS];
    logic signed [COEF_W-1:0]   coef_tab [NUM_BANDS][NUM_TAPS];
    logic [ENERGY_W-1:0]        energy [NUM_BANDS];
    logic [RATIO_W-1:0]         ratio;
    logic [RATIO_W-1:0]         decim_cnt;
    logic [ADDR_W-1:0]          wr_pos;
    energies_t                  energy_q [$];

    task automatic clear_state();
        for (int i = 0; i < NUM_TAPS; i++) begin
            sample_line[i] = '0;
            for (int b = 0; b < NUM_BANDS; b++) begin
                coef_tab[b][i] = '0;
            end
        end
        for (int b = 0; b < NUM_BANDS; b++) begin
            energy[b] = '0;
        end
        ratio = RATIO_RESET;
        decim_cnt = '0;
        wr_pos = ADDR_W'(NUM_TAPS - 1);
        energy_q.delete();
    endtask

    task automatic absorb_item(input logic [1:0] kind, input logic [63:0] data);
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W:0]   sum;
        logic [1:0]                 band;
        logic [INDEX_W-1:0]         idx;
        logic signed [COEF_W-1:0]   val;
        logic signed [31:0]         prod;
        logic signed [31:0]         low;
        logic [63:0]                sq;
        longint                     filt;
        logic [ADDR_W-1:0]          pos;
        left  = data[15:0];
        right = data[31:16];
        band  = data[33:32];
        idx   = data[41:34];
        val   = data[57:42];
        case (kind)
            KIND_SAMPLE: begin
                sum = left + right;
                pos = wr_pos;
                sample_line[pos] = sum[SAMPLE_W:1];
                decim_cnt = decim_cnt + 8'd1;
                if (decim_cnt >= ratio) begin
                    for (int b = 0; b < NUM_BANDS; b++) begin
                        filt = 0;
                        for (int i = 0; i < NUM_TAPS; i++) begin
                            prod = coef_tab[b][i] * sample_line[pos + ADDR_W'(i)];
                            filt = filt + (prod >>> Q_SHIFT);
                        end
                        sq = filt * filt;
                        low = sq[31:0];
                        low = low >>> Q_SHIFT;
                        energy[b] = energy[b] + low;
                    end
                    decim_cnt = '0;
                    filter_runs++;
                end
                wr_pos = pos - ADDR_W'(1);
            end
            KIND_COEF: begin
                // out of range index or band leaves the tables alone
                if (idx < NUM_TAPS && band <= BAND_TREBLE) begin
                    coef_tab[band][idx[ADDR_W-1:0]] = val;
                end
            end
            KIND_READ: begin
                energy_q.push_back(energies_t'{energy[0], energy[1], energy[2]});
                for (int b = 0; b < NUM_BANDS; b++) begin
                    energy[b] = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_energies(input logic [3*ENERGY_W-1:0] got);
        energies_t want;
        if (energy_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("%0t: energy transfer with none pending: %h", $time, got);
            end
        end else begin
            want = energy_q.pop_front();
            reads_checked++;
            if (got[0 +: ENERGY_W] !== want.bass || got[ENERGY_W +: ENERGY_W] !== want.mid ||
                    got[2*ENERGY_W +: ENERGY_W] !== want.treble) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: energy mismatch bass exp %h got %h, mid exp %h got %h,",
                             $time, want.bass, got[0 +: ENERGY_W], want.mid,
                             got[ENERGY_W +: ENERGY_W]);
                    $display("    treble exp %h got %h",
                             want.treble, got[2*ENERGY_W +: ENERGY_W]);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                ratio = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                absorb_item(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_energies(m_tdata);
            end
            outstanding <= energy_q.size();
        end
    end

endmodule

@@ test/three_band_audio_energy_core_test.sv @@
// testbench top for the three band audio energy core: reset, config writes, directed and
// random input transfers with random stalls on both sides; depends on tbae_pkg, the core
// and three_band_audio_energy_checker
`timescale 1ns / 1ps

module three_band_audio_energy_core_test
    import tbae_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] BAND_NONE   = 2'd3;
    localparam int         MAX_GAP     = 14;
    localparam int         PHASE_ITEMS = 245;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [RATIO_W-1:0]    cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;   // left, right, coef_band, coef_index, coef_value
    logic [1:0]            s_tuser;   // kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [3*ENERGY_W-1:0] m_tdata;   // bass_energy, mid_energy, treble_energy

    int fail_count;
    int outstanding;
    int reads_checked;
    int filter_runs;
    int items_sent;
    bit quiet;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    three_band_audio_energy_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    three_band_audio_energy_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .reads_checked (reads_checked),
        .filter_runs   (filter_runs)
    );

    task automatic send(input logic [1:0] kind, input logic [15:0] left, input logic [15:0] right,
                        input logic [1:0] band, input logic [7:0] idx, input logic [15:0] val);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, val, idx, band, right, left};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // ratio only changes with the core idle and every result drained
    task automatic set_ratio(input logic [RATIO_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            int stall;
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        logic [RATIO_W-1:0] ratios [8];
        int                 pick;
        logic [7:0]         idx;
        ratios = '{8'd255, 8'd3, 8'd0, 8'd200, 8'd2, 8'd1, 8'd0, 8'd16};
        ratios[6] = 8'($urandom_range(4, 254));
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_SAMPLE;
        quiet       = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send(KIND_COEF, 16'($urandom), 16'($urandom), BAND_BASS, 8'd0, 16'h7fff);
        send(KIND_COEF, 16'($urandom), 16'($urandom), BAND_MID, 8'd0, 16'h8000);
        send(KIND_COEF, 16'($urandom), 16'($urandom), BAND_TREBLE, 8'd31, 16'h8000);
        send(KIND_COEF, 16'($urandom), 16'($urandom), BAND_TREBLE, 8'd0, 16'h4000);
        send(KIND_COEF, 16'($urandom), 16'($urandom), BAND_BASS, 8'd1, 16'hffff);
        // band three and indexes past the last tap are dropped
        send(KIND_COEF, 16'($urandom), 16'($urandom), BAND_NONE, 8'd2, 16'h1234);
        send(KIND_COEF, 16'($urandom), 16'($urandom), BAND_MID, 8'd32, 16'h7fff);
        send(KIND_COEF, 16'($urandom), 16'($urandom), BAND_BASS, 8'd255, 16'h8000);
        // ratio of eight from reset still in force
        for (int n = 0; n < 20; n++) begin
            send(KIND_SAMPLE, 16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom),
                 16'($urandom));
        end
        send(KIND_READ, 16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
        set_ratio(8'd1);
        send(KIND_SAMPLE, 16'h7fff, 16'h7fff, 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_SAMPLE, 16'h8000, 16'h8000, 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_SAMPLE, 16'h7fff, 16'h8000, 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_SAMPLE, 16'hffff, 16'h0000, 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_SAMPLE, 16'h8000, 16'h7fff, 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_SAMPLE, 16'h0001, 16'h0001, 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_READ, 16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_UNUSED, 16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_READ, 16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));
        set_ratio(8'd0);
        send(KIND_SAMPLE, 16'h8000, 16'h8000, 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_SAMPLE, 16'h8000, 16'h8000, 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_SAMPLE, 16'h7fff, 16'h7fff, 2'($urandom), 8'($urandom), 16'($urandom));
        send(KIND_READ, 16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom), 16'($urandom));

        // the 200 phase leaves a high count that the drop to 2 cuts short
        for (int p = 0; p < 8; p++) begin
            set_ratio(ratios[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 39) == 0) begin
                    quiet = !quiet;
                end
                pick = $urandom_range(0, 99);
                idx = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, NUM_TAPS - 1));
                send(pick < 68 ? KIND_SAMPLE : pick < 83 ? KIND_COEF :
                     pick < 95 ? KIND_READ : KIND_UNUSED,
                     16'($urandom), 16'($urandom), 2'($urandom), idx, 16'($urandom));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("run covered %0d input transfers, %0d energy reads checked, %0d filter runs",
                 items_sent, reads_checked, filter_runs);
        $display("decimation ratios 0, 1, 2, 3, 8, 16, 200 lowered to 2, 255 and %0d", ratios[6]);
        if (fail_count == 0 && outstanding == 0) begin
            $display("three_band_audio_energy_core_test passed");
        end else begin
            $display("three_band_audio_energy_core_test failed");
        end
        $finish;
    end

    initial begin
        #7_000_000;
        $display("three_band_audio_energy_core_test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/tbae_pkg.sv
hdl/tbae_ram.sv
hdl/tbae_mac_unit.sv
hdl/tbae_seq.sv
hdl/three_band_audio_energy_core.sv
test/three_band_audio_energy_checker.sv
test/three_band_audio_energy_core_test.sv
